>>> hdl/box_filter_3x3_reflect_macros.svh
// Assertion macros used by the checker file of the box filter.
`ifndef BOX_FILTER_3X3_REFLECT_MACROS_SVH
`define BOX_FILTER_3X3_REFLECT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define BF3_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define BF3_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/bf3_pkg.sv
// Shared constants, types and codes of the 3x3 box filter.
package bf3_pkg;

  // Line memory depth: widest supported frame row.
  localparam int MAX_WIDTH  = 256;

  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int FW_REG_W   = 9;
  localparam int FH_REG_W   = 16;
  localparam int WUSE_W     = $clog2(MAX_WIDTH + 1);
  localparam int WCMP_W     = (FW_REG_W > WUSE_W) ? FW_REG_W : WUSE_W;
  localparam int ROW_W      = FH_REG_W + 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Column sum of three pixels and window sum of three columns.
  localparam int CSUM_W     = PIX_W + 2;
  localparam int WSUM_W     = PIX_W + 4;

  // floor(s / 9) = (s * 7282) >> 16, exact for s below 32768.
  localparam int RECIP9      = 7282;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = WSUM_W + RECIP_W;

  // Result queue in front of the output port.
  localparam int OUTQ_DEPTH = 8;
  localparam int QPTR_W     = $clog2(OUTQ_DEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  typedef logic [PIX_W-1:0] pix_t;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // Item kinds on the input stream.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Which column sums make up the window: left, centre, right.
  typedef enum logic [1:0] {
    WIN_BCV = 2'd0,   // interior column
    WIN_VCV = 2'd1,   // left border, column 1 mirrors in for column -1
    WIN_BCB = 2'd2    // right border, column W-2 mirrors in for column W
  } win_mode_t;

  // Item leaving the scan stage towards the line memory.
  typedef struct packed {
    pix_t             px;
    logic [COL_W-1:0] col;
    logic             has_px;
    logic             top_is_px;
    logic             emit;
    logic             last;
    win_mode_t        mode;
  } scan_item_t;

  // Item leaving the line memory stage: the new column sum.
  typedef struct packed {
    logic [CSUM_W-1:0] vsum;
    logic              emit;
    logic              last;
    win_mode_t         mode;
  } col_item_t;

  // Finished result.
  typedef struct packed {
    pix_t pixel;
    logic last;
  } out_item_t;

endpackage

>>> hdl/bf3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bf3_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/bf3_scan.sv
// Frame position counters, size registers and input item admission.
module bf3_scan (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bf3_pkg::PIX_W-1:0]      s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           space_ok,
  output logic                           rd_en,
  output logic [bf3_pkg::COL_W-1:0]      rd_addr,
  output logic                           s1_valid,
  output bf3_pkg::scan_item_t            s1_item
);
  import bf3_pkg::*;

  logic [FW_REG_W-1:0] frame_width;
  logic [FH_REG_W-1:0] frame_height;

  logic [COL_W-1:0]    in_col, in_col_next;
  logic [ROW_W-1:0]    in_row, in_row_next;
  logic [COL_W-1:0]    out_col, out_col_next;
  logic [FH_REG_W-1:0] out_row, out_row_next;

  logic [WCMP_W-1:0]   fw_ext;
  logic [WCMP_W-1:0]   w_used;
  logic [COL_W-1:0]    w_last;
  logic [FH_REG_W-1:0] h_used;
  logic [FH_REG_W-1:0] h_last;

  logic      accept, has_px, ignore, take, emit, last;
  logic      col_end, out_col_end;
  win_mode_t mode;

  // Frame sizes as used: width clamped to [2, MAX_WIDTH], height to at least 2.
  always_comb begin
    fw_ext = WCMP_W'(frame_width);
    if (fw_ext < WCMP_W'(2)) begin
      w_used = WCMP_W'(2);
    end else if (fw_ext > WCMP_W'(MAX_WIDTH)) begin
      w_used = WCMP_W'(MAX_WIDTH);
    end else begin
      w_used = fw_ext;
    end
    w_last = COL_W'(w_used - WCMP_W'(1));
    h_used = (frame_height < FH_REG_W'(2)) ? FH_REG_W'(2) : frame_height;
    h_last = h_used - FH_REG_W'(1);
  end

  // Admission: a drain item before the frame is complete is dropped unseen.
  assign s_axis_tready = space_ok;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign has_px        = in_row < ROW_W'(h_used);
  assign ignore        = has_px && (op_t'(s_axis_tuser) == OP_DRAIN);
  assign take          = accept && !ignore;

  // Position decode for the item at hand.
  always_comb begin
    col_end     = (in_col == w_last);
    out_col_end = (out_col == w_last);
    emit        = (in_row > ROW_W'(1)) || ((in_row == ROW_W'(1)) && (in_col != '0));
    last        = (out_row == h_last) && out_col_end;
    if (out_col == '0) begin
      mode = WIN_VCV;
    end else if (out_col_end) begin
      mode = WIN_BCB;
    end else begin
      mode = WIN_BCV;
    end
  end

  // Counter update; a register write or the final result restarts the frame.
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (cfg_we) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (take) begin
      in_col_next = col_end ? '0 : in_col + COL_W'(1);
      in_row_next = col_end ? in_row + ROW_W'(1) : in_row;
      if (emit) begin
        if (last) begin
          in_col_next  = '0;
          in_row_next  = '0;
          out_col_next = '0;
          out_row_next = '0;
        end else begin
          out_col_next = out_col_end ? '0 : out_col + COL_W'(1);
          out_row_next = out_col_end ? out_row + FH_REG_W'(1) : out_row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // Size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_REG_W'(256);
      frame_height <= FH_REG_W'(256);
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[FW_REG_W-1:0];
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data[FH_REG_W-1:0];
      end
    end
  end

  // Line memory read of the column now entering: rows r-1 and r-2.
  assign rd_en   = take;
  assign rd_addr = in_col;

  // Stage register towards the line memory stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item.px        <= s_axis_tdata;
      s1_item.col       <= in_col;
      s1_item.has_px    <= has_px;
      s1_item.top_is_px <= (in_row == ROW_W'(1));
      s1_item.emit      <= emit;
      s1_item.last      <= last;
      s1_item.mode      <= mode;
    end
  end

endmodule

>>> hdl/bf3_linebuf.sv
// Two-row line memory with read-modify-write and the column sum it feeds.
module bf3_linebuf (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [bf3_pkg::COL_W-1:0] rd_addr,
  input  logic                      s1_valid,
  input  bf3_pkg::scan_item_t       s1_item,
  output logic                      s2_valid,
  output bf3_pkg::col_item_t        s2_item
);
  import bf3_pkg::*;

  // Each entry holds one column: the row above in the upper byte,
  // the row two above in the lower byte.
  logic [2*PIX_W-1:0] rdata;
  logic [2*PIX_W-1:0] wdata;
  logic               we;
  pix_t               above, two_above;
  pix_t               top, mid, bot;
  logic [CSUM_W-1:0]  vsum;

  bf3_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_item.col),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Column of three with row mirroring: the first output row takes row 1
  // for row -1, the last takes row H-2 for row H.
  always_comb begin
    above     = rdata[2*PIX_W-1:PIX_W];
    two_above = rdata[PIX_W-1:0];
    top       = s1_item.top_is_px ? s1_item.px : two_above;
    mid       = above;
    bot       = s1_item.has_px ? s1_item.px : two_above;
    vsum      = CSUM_W'(top) + CSUM_W'(mid) + CSUM_W'(bot);
  end

  // Write back: the new pixel becomes the row above, the old one moves down.
  assign we    = s1_valid && s1_item.has_px;
  assign wdata = {s1_item.px, above};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_item.vsum <= vsum;
      s2_item.emit <= s1_item.emit;
      s2_item.last <= s1_item.last;
      s2_item.mode <= s1_item.mode;
    end
  end

endmodule

>>> hdl/bf3_mean.sv
// Window sum over three column sums and division by nine.
module bf3_mean (
  input  logic               clk,
  input  logic               rst,
  input  logic               s2_valid,
  input  bf3_pkg::col_item_t s2_item,
  output logic               push,
  output bf3_pkg::out_item_t push_item
);
  import bf3_pkg::*;

  logic [CSUM_W-1:0] bsum, csum;
  logic [CSUM_W-1:0] left, right;
  logic [WSUM_W-1:0] wsum;
  logic [WSUM_W-1:0] s3_sum;
  logic              s3_last;
  logic [PROD_W-1:0] prod;

  // Outer columns of the window, with column mirroring at both borders.
  always_comb begin
    unique case (s2_item.mode)
      WIN_BCV: begin
        left  = bsum;
        right = s2_item.vsum;
      end
      WIN_VCV: begin
        left  = s2_item.vsum;
        right = s2_item.vsum;
      end
      WIN_BCB: begin
        left  = bsum;
        right = bsum;
      end
      default: begin
        left  = bsum;
        right = s2_item.vsum;
      end
    endcase
    wsum = WSUM_W'(left) + WSUM_W'(csum) + WSUM_W'(right);
  end

  // Column sum history: every item moves the window one column on.
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      bsum <= csum;
      csum <= s2_item.vsum;
    end
  end

  // Sum register ahead of the multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= s2_valid && s2_item.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_item.emit) begin
      s3_sum  <= wsum;
      s3_last <= s2_item.last;
    end
  end

  // Division by nine as a multiplication by its scaled reciprocal.
  assign prod            = PROD_W'(s3_sum) * PROD_W'(RECIP9);
  assign push_item.pixel = prod[RECIP_SHIFT +: PIX_W];
  assign push_item.last  = s3_last;

endmodule

>>> hdl/bf3_outq.sv
// Result queue in front of the output port, with input admission credit.
module bf3_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  bf3_pkg::out_item_t        push_item,
  input  logic [1:0]                inflight,
  output logic                      space_ok,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [bf3_pkg::PIX_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast
);
  import bf3_pkg::*;

  out_item_t         slots [OUTQ_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic              pop;

  assign pop = m_axis_tvalid && m_axis_tready;

  // Occupancy.
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // A new item is admitted only while every item in flight has a slot.
  assign space_ok = (count + QCNT_W'(inflight)) < QCNT_W'(OUTQ_DEPTH);

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = slots[rd_ptr].pixel;
  assign m_axis_tlast  = slots[rd_ptr].last;

endmodule

>>> hdl/box_filter_3x3_reflect.sv
// Throughput: one item per clock while the queue has room, set by the single line memory RMW.
// An accepted item's result passes the s1, s2 and sum registers, then the result queue.
// Output pixel n of a frame is caused by input item n+W+1; W+1 drain items flush the frame.
// Reset (rst, synchronous): counters and queue cleared, frame size back to 256 x 256.
// The line memory is not cleared; stale entries read early in a frame never reach a result.
module box_filter_3x3_reflect (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bf3_pkg::PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in
  input  logic                           s_axis_tuser,   // [0] op
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bf3_pkg::PIX_W-1:0]      m_axis_tdata,   // [7:0] pixel_out
  output logic                           m_axis_tlast    // frame_last
);
  import bf3_pkg::*;

  logic             space_ok;
  logic             rd_en;
  logic [COL_W-1:0] rd_addr;
  logic             s1_valid;
  scan_item_t       s1_item;
  logic             s2_valid;
  col_item_t        s2_item;
  logic             push;
  out_item_t        push_item;
  logic [1:0]       inflight;

  // Items inside the pipeline that may still claim a queue slot.
  assign inflight = 2'(s1_valid) + 2'(s2_valid) + 2'(push);

  bf3_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .space_ok      (space_ok),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .s1_valid      (s1_valid),
    .s1_item       (s1_item)
  );

  bf3_linebuf u_linebuf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s2_valid (s2_valid),
    .s2_item  (s2_item)
  );

  bf3_mean u_mean (
    .clk       (clk),
    .rst       (rst),
    .s2_valid  (s2_valid),
    .s2_item   (s2_item),
    .push      (push),
    .push_item (push_item)
  );

  bf3_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_item     (push_item),
    .inflight      (inflight),
    .space_ok      (space_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> hdl/bf3_checker.sv
// Port-level assertions for the box filter and the bind that attaches them.
`include "box_filter_3x3_reflect_macros.svh"

module bf3_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [bf3_pkg::PIX_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);

  // A stalled result keeps its value.
  `BF3_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // Reset empties the result queue.
  `BF3_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid, "result shown right after reset")

  // With no result waiting, an offered item is never refused.
  `BF3_ASSERT_IMP(a_ready_when_empty, clk, rst, s_axis_tvalid && !m_axis_tvalid, s_axis_tready, "input refused while output queue empty")

  // The item after the final pixel of a frame opens the next frame.
  `BF3_ASSERT_NXT(a_last_alone, clk, rst, m_axis_tvalid && m_axis_tready && m_axis_tlast, !(m_axis_tvalid && m_axis_tlast), "two final pixels in a row")

endmodule

bind box_filter_3x3_reflect bf3_checker u_bf3_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
